/* hw/rtl/deq_pkg.sv */
`timescale 1ns / 1ps

package deq_pkg;

    // Payload widths fixed by the transaction format.
    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;

    // Default number of entries in the circular store.
    localparam int DEPTH_DEF = 64;

    // Operation codes carried by a request transaction.
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR      = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_DUMP       = 3'd3,
        OP_POP_FRONT  = 3'd4,
        OP_POP_BACK   = 3'd5
    } t_op;

    // Status codes carried by a response transaction.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

/* hw/rtl/deq_if.sv */
`timescale 1ns / 1ps

// Request channel: one operation and the value to push.
interface deq_in_if;
    import deq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value_in;

    modport source (output valid, output op, output value_in, input ready);
    modport sink   (input valid, input op, input value_in, output ready);
endinterface

// Response channel: popped or dumped element with status and run marker.
interface deq_out_if;
    import deq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value_out;
    logic [STATUS_W-1:0]      status;
    logic                     last;

    modport source (output valid, output value_out, output status, output last, input ready);
    modport sink   (input valid, input value_out, input status, input last, output ready);
endinterface

/* hw/rtl/double_ended_queue_core.sv */
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values kept in a circular
// store of DEPTH entries in a synchronous memory. Each request transaction
// carries an operation: clear, push front, push back, dump, pop front or
// pop back. Clear and accepted pushes give no response. A push to a full
// queue is dropped and answered with a full status; a pop from an empty
// queue is answered with an empty status and a zero value. A pop issues its
// memory read, and the element passes from the memory's read register into
// the response register. A dump of N elements gives N responses front to
// back, the final one marked by last; the single memory read port delivers
// one element per cycle while the receiver does not stall. One request is
// worked on at a time, and a request is taken only when the response
// register is free or being emptied in the same cycle. The store needs no
// clearing after reset; entries are only read after a push has written them.
module double_ended_queue_core #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deq_in_if.sink     i_req,
    deq_out_if.source  o_rsp
);
    import deq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_DUMP
    } t_state;

    // Control and response registers.
    t_state                   r_state,     n_state;
    logic [PTR_W-1:0]         r_front,     n_front;
    logic [CNT_W-1:0]         r_count,     n_count;
    logic [CNT_W-1:0]         r_idx,       n_idx;
    logic                     r_o_valid,   n_o_valid;
    logic signed [DATA_W-1:0] r_o_value,   n_o_value;
    t_status                  r_o_status,  n_o_status;
    logic                     r_o_last,    n_o_last;

    // Memory and its ports.
    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;
    logic                     wr_en;
    logic [PTR_W-1:0]         wr_addr;
    logic                     rd_en;
    logic [CNT_W-1:0]         rd_off;
    logic [PTR_W-1:0]         rd_addr;

    logic                     out_free;
    logic                     accept;
    logic                     full;
    logic                     empty;
    logic                     dump_last;

    // Position of the element that lies off places behind the front.
    function automatic logic [PTR_W-1:0] f_slot(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off[PTR_W-1:0]};
        if (sum >= (PTR_W+1)'(DEPTH)) begin
            sum = sum - (PTR_W+1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Handshake and queue status.
    assign out_free    = !r_o_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && out_free;
    assign accept      = i_req.valid && i_req.ready;
    assign full        = (r_count == CNT_W'(DEPTH));
    assign empty       = (r_count == '0);
    assign dump_last   = (r_idx == CNT_W'(r_count - CNT_W'(1)));
    assign rd_addr     = f_slot(r_front, rd_off);

    assign o_rsp.valid     = r_o_valid;
    assign o_rsp.value_out = r_o_value;
    assign o_rsp.status    = r_o_status;
    assign o_rsp.last      = r_o_last;

    // Next-state logic for the operation sequencer.
    always_comb begin
        n_state    = r_state;
        n_front    = r_front;
        n_count    = r_count;
        n_idx      = r_idx;
        n_o_valid  = r_o_valid && !o_rsp.ready;
        n_o_value  = r_o_value;
        n_o_status = r_o_status;
        n_o_last   = r_o_last;
        wr_en      = 1'b0;
        wr_addr    = r_front;
        rd_en      = 1'b0;
        rd_off     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_op'(i_req.op))
                        OP_CLEAR: begin
                            n_front = '0;
                            n_count = '0;
                        end
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (full) begin
                                n_o_valid  = 1'b1;
                                n_o_value  = '0;
                                n_o_status = ST_FULL;
                                n_o_last   = 1'b1;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = CNT_W'(r_count + CNT_W'(1));
                                if (t_op'(i_req.op) == OP_PUSH_FRONT) begin
                                    n_front = (r_front == '0) ? PTR_W'(DEPTH - 1)
                                                              : PTR_W'(r_front - PTR_W'(1));
                                    wr_addr = n_front;
                                end else begin
                                    wr_addr = f_slot(r_front, r_count);
                                end
                            end
                        end
                        OP_DUMP: begin
                            if (!empty) begin
                                rd_en   = 1'b1;
                                rd_off  = '0;
                                n_idx   = '0;
                                n_state = S_DUMP;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (empty) begin
                                n_o_valid  = 1'b1;
                                n_o_value  = '0;
                                n_o_status = ST_EMPTY;
                                n_o_last   = 1'b1;
                            end else begin
                                rd_en   = 1'b1;
                                n_count = CNT_W'(r_count - CNT_W'(1));
                                n_state = S_POP;
                                if (t_op'(i_req.op) == OP_POP_FRONT) begin
                                    rd_off  = '0;
                                    n_front = (r_front == PTR_W'(DEPTH - 1)) ? '0
                                                : PTR_W'(r_front + PTR_W'(1));
                                end else begin
                                    rd_off = CNT_W'(r_count - CNT_W'(1));
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_value  = r_rd_data;
                    n_o_status = ST_OK;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DUMP: begin
                // The read data always belongs to the element at r_idx.
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_value  = r_rd_data;
                    n_o_status = ST_OK;
                    n_o_last   = dump_last;
                    if (dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en  = 1'b1;
                        rd_off = CNT_W'(r_idx + CNT_W'(1));
                        n_idx  = CNT_W'(r_idx + CNT_W'(1));
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered response.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_front   <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_front    <= n_front;
            r_count    <= n_count;
            r_o_valid  <= n_o_valid;
            r_idx      <= n_idx;
            r_o_value  <= n_o_value;
            r_o_status <= n_o_status;
            r_o_last   <= n_o_last;
        end
    end

    // Element store with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_req.value_in;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/deq_checker.sv */
`timescale 1ns / 1ps

module deq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_req_valid,
    input logic                              i_req_ready,
    input logic                              i_rsp_valid,
    input logic                              i_rsp_ready,
    input logic signed [deq_pkg::DATA_W-1:0] i_rsp_value,
    input logic [deq_pkg::STATUS_W-1:0]      i_rsp_status,
    input logic                              i_rsp_last
);
    import deq_pkg::*;

    // An error response carries no element and ends its run.
    a_err_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != ST_OK) |-> (i_rsp_value == '0 && i_rsp_last))
        else $error("error response with nonzero value or without last");

    // A new request is never taken while a response is stalled.
    a_no_take_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_ready |-> !(i_rsp_valid && !i_rsp_ready))
        else $error("request taken while response stalled");

    // A stalled response holds its contents.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_value) && $stable(i_rsp_status)
             && $stable(i_rsp_last)))
        else $error("stalled response changed");

    // Reset leaves no response pending.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_value  (o_rsp.value_out),
    .i_rsp_status (o_rsp.status),
    .i_rsp_last   (o_rsp.last)
);

/* test/double_ended_queue_core_tb.sv */
`timescale 1ns / 1ps

module double_ended_queue_core_tb;
    import deq_pkg::*;

    localparam int DEPTH     = DEPTH_DEF;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int MAX_CYCLE = 1000000;
    localparam int MAX_SHOWN = 10;

    // Operation codes that the block must ignore.
    localparam logic [OP_W-1:0] OP_RSVD_A = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_B = 3'd7;

    // One response transaction as the queue model predicts it.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        t_status                  status;
        logic                     last;
    } t_deq_rsp;

    logic i_clk;
    logic i_rst_n;

    deq_in_if  req_if ();
    deq_out_if rsp_if ();

    double_ended_queue_core #(
        .DEPTH (DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Queue model state.
    logic signed [DATA_W-1:0] model_store [DEPTH];
    logic [IDX_W-1:0]         model_head;
    logic [CNT_W-1:0]         model_count;

    // Responses that the model has predicted and the block has not yet given.
    t_deq_rsp awaited_rsp [$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count;
    int cycle_count;

    // 50 MHz clock.
    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // The run is cut short if it takes far longer than the slowest correct run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= MAX_CYCLE) begin
            $display("double_ended_queue_core_tb: FAIL");
            $finish;
        end
    end

    // The receiver stalls at random according to the current idle rate.
    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Counts a mismatch and shows the first few of them.
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    // Applies one request to the queue model and queues the responses it causes.
    task automatic predict_deque_op(input logic [OP_W-1:0] op,
                                    input logic signed [DATA_W-1:0] val);
        int slot;
        case (op)
            OP_CLEAR: begin
                model_head  = '0;
                model_count = '0;
            end
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (model_count >= DEPTH) begin
                    awaited_rsp.push_back(t_deq_rsp'{'0, ST_FULL, 1'b1});
                end else if (op == OP_PUSH_FRONT) begin
                    model_head = IDX_W'((int'(model_head) + DEPTH - 1) % DEPTH);
                    model_store[model_head] = val;
                    model_count++;
                end else begin
                    slot = (int'(model_head) + int'(model_count)) % DEPTH;
                    model_store[IDX_W'(slot)] = val;
                    model_count++;
                end
            end
            OP_DUMP: begin
                for (int i = 0; i < int'(model_count); i++) begin
                    slot = (int'(model_head) + i) % DEPTH;
                    awaited_rsp.push_back(t_deq_rsp'{model_store[IDX_W'(slot)], ST_OK,
                                                     (i == int'(model_count) - 1)});
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (model_count == 0) begin
                    awaited_rsp.push_back(t_deq_rsp'{'0, ST_EMPTY, 1'b1});
                end else if (op == OP_POP_FRONT) begin
                    awaited_rsp.push_back(t_deq_rsp'{model_store[model_head], ST_OK, 1'b1});
                    model_head = IDX_W'((int'(model_head) + 1) % DEPTH);
                    model_count--;
                end else begin
                    slot = (int'(model_head) + int'(model_count) - 1) % DEPTH;
                    awaited_rsp.push_back(t_deq_rsp'{model_store[IDX_W'(slot)], ST_OK,
                                                     1'b1});
                    model_count--;
                end
            end
            default: begin
                // Undefined codes leave the queue alone.
            end
        endcase
    endtask

    // Sends one request transaction, with random idle cycles ahead of it.
    // Valid stays high after acceptance so back-to-back requests need no gap.
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.op       <= op;
        req_if.value_in <= val;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        predict_deque_op(op, val);
    endtask

    // Holds the request side quiet until every predicted response has arrived.
    task automatic wait_for_drain();
        req_if.valid <= 1'b0;
        while (awaited_rsp.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random value with the extremes mixed in.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Checks every response transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_deq_rsp got;
        t_deq_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = t_deq_rsp'{rsp_if.value_out, t_status'(rsp_if.status), rsp_if.last};
            if (awaited_rsp.size() == 0) begin
                report_mismatch($sformatf({"response with none outstanding: ",
                                           "value %0d status %0d last %0b"},
                                          got.value, got.status, got.last));
            end else begin
                want = awaited_rsp.pop_front();
                if (got.value !== want.value || got.status !== want.status
                        || got.last !== want.last) begin
                    report_mismatch($sformatf({"response mismatch: expected value %0d status %0d ",
                                               "last %0b, got value %0d status %0d last %0b"},
                                              want.value, want.status, want.last,
                                              got.value, got.status, got.last));
                end
            end
        end
    end

    // Empty-queue pops, extreme values, index wrap, ignored codes and clear.
    task automatic test_directed_edges();
        send_request(OP_POP_FRONT, 32'sd17);
        send_request(OP_POP_BACK, -32'sd17);
        send_request(OP_DUMP, '0);
        send_request(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_request(OP_PUSH_BACK, 32'sh8000_0000);
        send_request(OP_PUSH_FRONT, '0);
        send_request(OP_PUSH_BACK, -32'sd1);
        send_request(OP_DUMP, 32'sh1234_5678);
        send_request(OP_POP_FRONT, '0);
        send_request(OP_POP_BACK, '0);
        send_request(OP_RSVD_A, 32'sh1234_5678);
        send_request(OP_RSVD_B, -32'sd1);
        send_request(OP_DUMP, '0);
        send_request(OP_CLEAR, -32'sd1);
        send_request(OP_DUMP, '0);
        send_request(OP_POP_BACK, '0);
        send_request(OP_PUSH_BACK, 32'sh5555_5555);
        send_request(OP_PUSH_FRONT, 32'shAAAA_AAAA);
        send_request(OP_POP_BACK, '0);
        send_request(OP_POP_FRONT, '0);
        send_request(OP_POP_FRONT, '0);
    endtask

    // Fills the queue from both ends, pushes into a full queue, dumps it
    // whole, then pops it empty from both ends and once more.
    task automatic test_fill_and_drain();
        while (model_count < DEPTH) begin
            send_request($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
        end
        send_request(OP_PUSH_FRONT, pick_value());
        send_request(OP_PUSH_BACK, pick_value());
        send_request(OP_DUMP, pick_value());
        while (model_count > 0) begin
            send_request($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, pick_value());
        end
        send_request(OP_POP_BACK, pick_value());
    endtask

    // Random mix of every operation, weighted toward pushes and pops.
    task automatic test_random_traffic(input int n_items);
        logic [OP_W-1:0] op;
        int roll;
        for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(99);
            if (roll < 3) begin
                op = OP_CLEAR;
            end else if (roll < 29) begin
                op = OP_PUSH_FRONT;
            end else if (roll < 55) begin
                op = OP_PUSH_BACK;
            end else if (roll < 62) begin
                op = OP_DUMP;
            end else if (roll < 79) begin
                op = OP_POP_FRONT;
            end else if (roll < 96) begin
                op = OP_POP_BACK;
            end else begin
                op = $urandom_range(1) ? OP_RSVD_A : OP_RSVD_B;
            end
            send_request(op, pick_value());
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.op       = OP_CLEAR;
        req_if.value_in = '0;
        rsp_if.ready    = 1'b0;
        send_idle_pct   = 15;
        recv_idle_pct   = 82;
        mismatch_count  = 0;
        cycle_count     = 0;
        model_head      = '0;
        model_count     = '0;
        for (int i = 0; i < DEPTH; i++) begin
            model_store[IDX_W'(i)] = '0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Slow receiver.
        test_directed_edges();
        wait_for_drain();
        test_fill_and_drain();
        wait_for_drain();

        // Slow sender.
        send_idle_pct = 82;
        recv_idle_pct = 15;
        test_random_traffic(40);
        wait_for_drain();

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(40);
        wait_for_drain();

        repeat (DEPTH + 20) @(posedge i_clk);
        if (awaited_rsp.size() != 0) begin
            report_mismatch($sformatf("%0d responses never arrived", awaited_rsp.size()));
        end

        if (mismatch_count == 0) begin
            $display("double_ended_queue_core_tb: PASS");
        end else begin
            $display("double_ended_queue_core_tb: FAIL");
        end
        $finish;
    end

endmodule
